FILE: sv/gdd_pkg.sv
// types, constants and calendar tables for the gregorian date difference block
// no dependencies; used by gdd_year_walk and gregorian_date_difference
package gdd_pkg;

	localparam int YEAR_W = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W = 5;
	localparam int DIFF_W = 23;
	localparam int ACC_W = 24;
	localparam int DOY_W = 9;

	localparam logic signed [ACC_W-1:0] DIFF_MAX = 24'sd4194303;
	localparam logic signed [ACC_W-1:0] DIFF_MIN = -24'sd4194304;

	localparam logic [6:0] CENTURY_LAST = 7'd99;
	localparam logic [8:0] QUAD_CENTURY_LAST = 9'd399;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [DOY_W-1:0] YEAR_DAYS = 9'd365;

	// input word: two dates
	typedef struct packed {
		logic [YEAR_W-1:0]  first_year;
		logic [MONTH_W-1:0] first_month;
		logic [DAY_W-1:0]   first_day;
		logic [YEAR_W-1:0]  second_year;
		logic [MONTH_W-1:0] second_month;
		logic [DAY_W-1:0]   second_day;
	} gdd_in_t;

	// output word
	typedef struct packed {
		logic signed [DIFF_W-1:0] day_difference;
		logic                     bad_date;
	} gdd_out_t;

	// year walker control and status
	typedef struct packed {
		logic clear;
		logic step;
	} gdd_walk_ctrl_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic              leap;
	} gdd_walk_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_DAY1,
		S_DAY2,
		S_FIN
	} gdd_state_t;

	// days in a month of a common year
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1:    len = 5'd31;
			4'd2:    len = 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// days of a common year before the first of a month
	function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] n;
		case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	// zero-based day of year
	function automatic logic [DOY_W-1:0] day_of_year(input logic [MONTH_W-1:0] m,
			input logic [DAY_W-1:0] d, input logic leap);
		logic [DOY_W-1:0] n;
		n = days_before(m) + DOY_W'(d) - 9'd1;
		if (m > MONTH_FEB && leap) begin
			n = n + 9'd1;
		end
		return n;
	endfunction

endpackage

FILE: sv/gdd_year_walk.sv
// year walker: counts years up from zero and tracks the leap rule incrementally
// depends on gdd_pkg
module gdd_year_walk (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gdd_pkg::gdd_walk_ctrl_t ctrl,
	output gdd_pkg::gdd_walk_stat_t stat
);
	import gdd_pkg::*;

	logic [YEAR_W-1:0] year_q;
	logic [6:0]        cent_q;
	logic [8:0]        quad_q;

	// year counter with residues mod 100 and mod 400
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q <= '0;
			cent_q <= '0;
			quad_q <= '0;
		end else if (ctrl.clear) begin
			year_q <= '0;
			cent_q <= '0;
			quad_q <= '0;
		end else if (ctrl.step) begin
			year_q <= year_q + 1'b1;
			cent_q <= (cent_q == CENTURY_LAST) ? '0 : cent_q + 1'b1;
			quad_q <= (quad_q == QUAD_CENTURY_LAST) ? '0 : quad_q + 1'b1;
		end
	end

	// divisible by 400, or by 4 and not by 100
	assign stat.year = year_q;
	assign stat.leap = (quad_q == '0) || ((year_q[1:0] == 2'b00) && (cent_q != '0));

endmodule

FILE: sv/gregorian_date_difference.sv
// top level of the gregorian date difference block: sequencer, shared adder, output register
// depends on gdd_pkg and gdd_year_walk
//
//  channel | signals                      | carries
//  --------+------------------------------+--------------------------------------
//  in      | in_valid, in_ready, in_word  | two dates, gdd_in_t
//  out     | out_valid, out_ready, out_word | day difference and bad flag, gdd_out_t
//
// for each word the year walker steps one year a cycle from zero up to the
// larger year, feeding one shared adder. a word with a year above YEAR_MAX or a
// bad month or zero day skips the walk and goes straight to the finish state.
// in_ready is high only while the sequencer is idle; a finished word waits in
// the output register, so the next word can be taken while out_ready is low.
// reset clears the sequencer, walker and output valid; no clearing pass.
module gregorian_date_difference #(
	parameter int unsigned YEAR_MAX = 9999
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gdd_pkg::gdd_in_t  in_word,
	output logic             out_valid,
	input  logic             out_ready,
	output gdd_pkg::gdd_out_t out_word
);
	import gdd_pkg::*;

	gdd_state_t state_q, state_d;
	gdd_in_t item_q;
	gdd_out_t out_word_q;
	gdd_walk_ctrl_t walk_ctrl;
	gdd_walk_stat_t walk_stat;
	logic out_valid_q;
	logic signed [ACC_W-1:0] acc_q, addend, acc_sum;
	logic bad_q, leap1_q, leap2_q;
	logic early_bad, day_bad, load_out, accept;
	logic up;
	logic [YEAR_W-1:0] year_lo, year_hi;
	logic [DOY_W-1:0] year_len;
	logic signed [DIFF_W-1:0] sat_diff;

	gdd_year_walk u_walk (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (walk_ctrl),
		.stat  (walk_stat)
	);

	// checks that need no leap flag
	always_comb begin
		early_bad = ({2'b00, in_word.first_year} > 16'(YEAR_MAX))
			|| ({2'b00, in_word.second_year} > 16'(YEAR_MAX))
			|| !(in_word.first_month inside {[4'd1:4'd12]})
			|| !(in_word.second_month inside {[4'd1:4'd12]})
			|| (in_word.first_day == '0) || (in_word.second_day == '0);
	end

	// day against month length, once the leap flags are known
	always_comb begin
		day_bad = ({1'b0, item_q.first_day} > ({1'b0, month_len(item_q.first_month)}
				+ 6'((item_q.first_month == MONTH_FEB) && leap1_q)))
			|| ({1'b0, item_q.second_day} > ({1'b0, month_len(item_q.second_month)}
				+ 6'((item_q.second_month == MONTH_FEB) && leap2_q)));
	end

	// year span and direction
	assign up = item_q.first_year > item_q.second_year;
	assign year_lo = up ? item_q.second_year : item_q.first_year;
	assign year_hi = up ? item_q.first_year : item_q.second_year;
	assign year_len = YEAR_DAYS + DOY_W'(walk_stat.leap);

	// shared adder operand
	always_comb begin
		addend = '0;
		case (state_q)
			S_WALK: begin
				if (walk_stat.year >= year_lo && walk_stat.year < year_hi) begin
					addend = up ? $signed(ACC_W'(year_len)) : -$signed(ACC_W'(year_len));
				end
			end
			S_DAY1: addend = $signed(ACC_W'(day_of_year(item_q.first_month,
				item_q.first_day, leap1_q)));
			S_DAY2: addend = -$signed(ACC_W'(day_of_year(item_q.second_month,
				item_q.second_day, leap2_q)));
			default: addend = '0;
		endcase
	end
	assign acc_sum = acc_q + addend;

	// saturate to the output width
	always_comb begin
		if (acc_q > DIFF_MAX) begin
			sat_diff = DIFF_MAX[DIFF_W-1:0];
		end else if (acc_q < DIFF_MIN) begin
			sat_diff = DIFF_MIN[DIFF_W-1:0];
		end else begin
			sat_diff = acc_q[DIFF_W-1:0];
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		walk_ctrl = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					walk_ctrl.clear = 1'b1;
					state_d = early_bad ? S_FIN : S_WALK;
				end
			end
			S_WALK: begin
				if (walk_stat.year == year_hi) begin
					state_d = S_DAY1;
				end else begin
					walk_ctrl.step = 1'b1;
				end
			end
			S_DAY1: state_d = S_DAY2;
			S_DAY2: state_d = S_FIN;
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
	assign accept = in_valid && in_ready;

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_word;
			bad_q <= early_bad;
			acc_q <= '0;
		end else if (state_q == S_WALK || state_q == S_DAY1 || state_q == S_DAY2) begin
			acc_q <= acc_sum;
		end
		if (state_q == S_WALK) begin
			if (walk_stat.year == item_q.first_year) begin
				leap1_q <= walk_stat.leap;
			end
			if (walk_stat.year == item_q.second_year) begin
				leap2_q <= walk_stat.leap;
			end
		end
		if (state_q == S_DAY1) begin
			bad_q <= bad_q || day_bad;
		end
		if (load_out) begin
			out_word_q.bad_date <= bad_q;
			out_word_q.day_difference <= bad_q ? '0 : sat_diff;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	// a flagged word always carries zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_word_q.bad_date |-> out_word_q.day_difference == '0)
		else $error("bad date with nonzero difference");

	// walker never passes the larger year
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> walk_stat.year <= year_hi)
		else $error("year walk overran");

	// an accepted word goes to the walk or straight to finish
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_WALK || state_q == S_FIN)
		else $error("accept did not start sequencer");

	// finish with a free output register delivers and returns to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && (!out_valid_q || out_ready) |=> out_valid_q && state_q == S_IDLE)
		else $error("finish did not load output");

endmodule

FILE: bench/gregorian_date_difference_tb.sv
// self-checking bench for gregorian_date_difference: directed date pairs, then random ones
// depends on gdd_pkg and gregorian_date_difference; expected differences come from a
// day-count predictor kept in this file
module gregorian_date_difference_tb;
	import gdd_pkg::*;

	localparam int unsigned LAST_YEAR = 9999;
	localparam int SPAN_DAYS = 3652424;
	localparam int RANDOM_WORDS = 78;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		gdd_in_t  dates;
		gdd_out_t want;
	} due_diff_t;

	typedef struct {
		gdd_in_t  dates;
		bit       typed;
		gdd_out_t want;
	} date_case_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	gdd_in_t in_word;
	logic out_valid;
	logic out_ready;
	gdd_out_t out_word;

	due_diff_t pending_diffs[$];
	date_case_t directed_cases[$];
	int send_idle_pct;
	int drain_stall_pct;
	int words_sent;
	int words_checked;
	int bad_seen;
	int far_words;
	int mismatches;

	gregorian_date_difference #(
		.YEAR_MAX(LAST_YEAR)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	always #5 clk = ~clk;

	// calendar rules
	function automatic bit is_leap(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11: return 30;
			MONTH_FEB: return is_leap(y) ? 29 : 28;
			default: return 0;
		endcase
	endfunction

	function automatic bit date_valid(input int unsigned y, input int unsigned m,
			input int unsigned d);
		return (y <= LAST_YEAR) && (m >= 1) && (m <= 12) && (d >= 1)
			&& (d <= month_days(y, m));
	endfunction

	// days elapsed since the first of january of year zero
	function automatic int day_count(input int unsigned y, input int unsigned m,
			input int unsigned d);
		int n;
		int unsigned k;
		n = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		for (k = 1; k < m; k++) begin
			n += month_days(y, k);
		end
		return n + d - 1;
	endfunction

	// expected result word for one pair of dates
	function automatic gdd_out_t predict_difference(input gdd_in_t w);
		gdd_out_t r;
		int diff;
		r = '0;
		if (date_valid(w.first_year, w.first_month, w.first_day)
				&& date_valid(w.second_year, w.second_month, w.second_day)) begin
			diff = day_count(w.first_year, w.first_month, w.first_day)
				- day_count(w.second_year, w.second_month, w.second_day);
			if (diff > int'(DIFF_MAX)) begin
				diff = int'(DIFF_MAX);
			end
			if (diff < int'(DIFF_MIN)) begin
				diff = int'(DIFF_MIN);
			end
			r.day_difference = DIFF_W'(diff);
		end else begin
			r.bad_date = 1'b1;
		end
		return r;
	endfunction

	function automatic gdd_in_t date_pair(input int unsigned y1, input int unsigned m1,
			input int unsigned d1, input int unsigned y2, input int unsigned m2,
			input int unsigned d2);
		gdd_in_t w;
		w.first_year = YEAR_W'(y1);
		w.first_month = MONTH_W'(m1);
		w.first_day = DAY_W'(d1);
		w.second_year = YEAR_W'(y2);
		w.second_month = MONTH_W'(m2);
		w.second_day = DAY_W'(d2);
		return w;
	endfunction

	task automatic add_case(input int unsigned y1, input int unsigned m1, input int unsigned d1,
			input int unsigned y2, input int unsigned m2, input int unsigned d2,
			input bit typed, input int diff, input bit bad);
		date_case_t c;
		c.dates = date_pair(y1, m1, d1, y2, m2, d2);
		c.typed = typed;
		c.want.day_difference = DIFF_W'(diff);
		c.want.bad_date = bad;
		directed_cases.push_back(c);
	endtask

	// mostly small years so the walk stays short, a few near the top of the range
	function automatic int unsigned pick_year();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return $urandom_range(9000, LAST_YEAR);
		end else if (r < 22) begin
			return $urandom_range(1500, 2500);
		end
		return $urandom_range(0, 450);
	endfunction

	function automatic int unsigned pick_day(input int unsigned y, input int unsigned m);
		int unsigned len;
		len = month_days(y, m);
		return ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len);
	endfunction

	// valid date pairs with random content, plus raw noise over the full field widths
	function automatic gdd_in_t random_dates();
		int unsigned y1, m1, d1, y2, m2, d2;
		if ($urandom_range(0, 99) < 15) begin
			return date_pair($urandom_range(0, 16383), $urandom_range(0, 15),
				$urandom_range(0, 31), $urandom_range(0, 16383), $urandom_range(0, 15),
				$urandom_range(0, 31));
		end
		y1 = pick_year();
		m1 = $urandom_range(1, 12);
		d1 = pick_day(y1, m1);
		y2 = ($urandom_range(0, 2) == 0) ? y1 : pick_year();
		m2 = $urandom_range(1, 12);
		d2 = pick_day(y2, m2);
		return date_pair(y1, m1, d1, y2, m2, d2);
	endfunction

	// offer one word, starting and ending at a falling edge
	task automatic send_word(input gdd_in_t w, input gdd_out_t want);
		due_diff_t due;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		due.dates = w;
		due.want = want;
		pending_diffs.push_back(due);
		words_sent++;
		if ((w.first_year >= 9000 && w.first_year <= LAST_YEAR)
				|| (w.second_year >= 9000 && w.second_year <= LAST_YEAR)) begin
			far_words++;
		end
		@(negedge clk);
	endtask

	// hold off the sender until every outstanding difference has come back
	task automatic drain_to_empty();
		in_valid <= 1'b0;
		while (pending_diffs.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= arst_n && ($urandom_range(0, 99) >= drain_stall_pct);
	end

	// compare each returned word with the oldest expectation
	always @(posedge clk) begin
		due_diff_t head;
		if (arst_n && out_valid && out_ready) begin
			if (pending_diffs.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("unexpected word: diff %0d bad %0b",
						$signed(out_word.day_difference), out_word.bad_date);
				end
			end else begin
				head = pending_diffs.pop_front();
				words_checked++;
				if (out_word.bad_date) begin
					bad_seen++;
				end
				if (out_word.day_difference !== head.want.day_difference
						|| out_word.bad_date !== head.want.bad_date) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("mismatch %0d-%0d-%0d minus %0d-%0d-%0d: expected %0d/%0b, got %0d/%0b",
							head.dates.first_year, head.dates.first_month,
							head.dates.first_day, head.dates.second_year,
							head.dates.second_month, head.dates.second_day,
							$signed(head.want.day_difference), head.want.bad_date,
							$signed(out_word.day_difference), out_word.bad_date);
					end
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		gdd_in_t w;
		int phase;
		int k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		out_ready = 1'b0;
		send_idle_pct = 12;
		drain_stall_pct = 86;
		words_sent = 0;
		words_checked = 0;
		bad_seen = 0;
		far_words = 0;
		mismatches = 0;

		// identical dates, full span both ways, bad dates of every kind
		add_case(0, 1, 1, 0, 1, 1, 1'b1, 0, 1'b0);
		add_case(9999, 12, 31, 0, 1, 1, 1'b1, SPAN_DAYS, 1'b0);
		add_case(0, 1, 1, 9999, 12, 31, 1'b1, -SPAN_DAYS, 1'b0);
		add_case(1900, 2, 29, 1900, 1, 1, 1'b1, 0, 1'b1);
		add_case(10000, 1, 1, 0, 1, 1, 1'b1, 0, 1'b1);
		add_case(16383, 15, 31, 16383, 15, 31, 1'b1, 0, 1'b1);
		add_case(5, 0, 10, 5, 1, 1, 1'b1, 0, 1'b1);
		add_case(5, 13, 10, 5, 1, 1, 1'b1, 0, 1'b1);
		add_case(7, 6, 0, 7, 6, 1, 1'b1, 0, 1'b1);
		add_case(123, 4, 31, 123, 4, 1, 1'b1, 0, 1'b1);
		add_case(23, 1, 1, 23, 6, 31, 1'b1, 0, 1'b1);
		add_case(3, 2, 29, 3, 2, 28, 1'b1, 0, 1'b1);
		// year zero as a leap year, century and quad-century rules, year edges, one more bad month
		add_case(0, 2, 29, 0, 2, 28, 1'b0, 0, 1'b0);
		add_case(0, 3, 1, 0, 2, 29, 1'b0, 0, 1'b0);
		add_case(0, 12, 31, 0, 1, 1, 1'b0, 0, 1'b0);
		add_case(1, 1, 1, 0, 12, 31, 1'b0, 0, 1'b0);
		add_case(400, 3, 1, 399, 3, 1, 1'b0, 0, 1'b0);
		add_case(300, 3, 1, 300, 2, 28, 1'b0, 0, 1'b0);
		add_case(2000, 2, 29, 1999, 2, 28, 1'b0, 0, 1'b0);
		add_case(2100, 2, 28, 2100, 3, 1, 1'b0, 0, 1'b0);
		add_case(9999, 12, 31, 9999, 1, 1, 1'b0, 0, 1'b0);
		add_case(8, 15, 31, 9999, 12, 31, 1'b0, 0, 1'b0);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_cases[i]) begin
			send_word(directed_cases[i].dates, directed_cases[i].typed
				? directed_cases[i].want : predict_difference(directed_cases[i].dates));
		end

		for (phase = 0; phase < 3; phase++) begin
			if (phase > 0) begin
				drain_to_empty();
			end
			send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 86 : 0;
			drain_stall_pct = (phase == 0) ? 86 : (phase == 1) ? 12 : 0;
			for (k = 0; k < RANDOM_WORDS / 3; k++) begin
				w = random_dates();
				send_word(w, predict_difference(w));
			end
		end

		drain_to_empty();
		// room for a stray word from a full-length walk
		repeat (LAST_YEAR + 16) @(posedge clk);

		$display("sent %0d date pairs (%0d directed, %0d reaching year 9000 or later)",
			words_sent, directed_cases.size(), far_words);
		$display("checked %0d differences, %0d flagged bad, %0d mismatches",
			words_checked, bad_seen, mismatches);
		if (mismatches == 0 && pending_diffs.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// hang guard
	initial begin
		#100000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
